>>> hw/rtl/ogdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Obstacle inflation package
// Shared sizes, codes and constants of the occupancy grid inflation block.
// ----------------------------------------------------------------------------
package ogdi_pkg;

   // Store geometry and radius limit
   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 256;
   localparam int MAX_RADIUS  = 31;

   localparam int ADDR_W   = $clog2(MAX_COLUMNS * MAX_ROWS);
   localparam int DEPTH    = MAX_COLUMNS * MAX_ROWS;
   localparam int COORD_W  = 8;
   localparam int VALUE_W  = 8;
   localparam int DIM_W    = 9;
   localparam int CFG_RAD_W = 5;
   localparam int CSR_W    = 9;
   localparam int RAD_BITS = $clog2(MAX_RADIUS + 1);
   localparam int OFF_BITS = RAD_BITS + 1;
   localparam int SQ_BITS  = 2 * RAD_BITS + 1;
   localparam int POS_W    = COORD_W + 2;

   localparam logic signed [VALUE_W-1:0] OBSTACLE_LEVEL = 8'sd50;
   localparam logic signed [VALUE_W-1:0] LETHAL_VALUE   = 8'sd100;
   localparam logic signed [VALUE_W-1:0] UNKNOWN_VALUE  = -8'sd1;

   localparam logic [DIM_W-1:0]     RESET_COLUMNS = 9'd256;
   localparam logic [DIM_W-1:0]     RESET_ROWS    = 9'd256;
   localparam logic [CFG_RAD_W-1:0] RESET_INNER   = 5'd10;
   localparam logic [CFG_RAD_W-1:0] RESET_OUTER   = 5'd15;

   typedef enum logic [1:0] {
      CSR_MAP_COLUMNS  = 2'd0,
      CSR_MAP_ROWS     = 2'd1,
      CSR_INNER_RADIUS = 2'd2,
      CSR_OUTER_RADIUS = 2'd3
   } csr_index_type;

   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   function automatic logic [RAD_BITS-1:0] sat_radius(input logic [CFG_RAD_W-1:0] v);
      if (int'(v) > MAX_RADIUS) begin
         return RAD_BITS'(MAX_RADIUS);
      end
      return RAD_BITS'(v);
   endfunction

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v, input int lim);
      if (int'(v) > lim) begin
         return DIM_W'(lim);
      end
      return v;
   endfunction

endpackage

>>> hw/rtl/ogdi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Obstacle inflation channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface ogdi_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  action;
   logic [ogdi_pkg::COORD_W-1:0]          cell_col;
   logic [ogdi_pkg::COORD_W-1:0]          cell_row;
   logic signed [ogdi_pkg::VALUE_W-1:0]   cell_value;

   modport source (output valid, action, cell_col, cell_row, cell_value, input ready);
   modport sink   (input valid, action, cell_col, cell_row, cell_value, output ready);
endinterface

interface ogdi_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ogdi_pkg::VALUE_W-1:0]   inner_value;
   logic signed [ogdi_pkg::VALUE_W-1:0]   outer_value;

   modport source (output valid, inner_value, outer_value, input ready);
   modport sink   (input valid, inner_value, outer_value, output ready);
endinterface

>>> hw/rtl/ogdi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ogdi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/occupancy_grid_disc_inflation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid disc inflation
// Loads cells into the grid store and answers inflated values for two radii.
// ----------------------------------------------------------------------------
// Load: taken in the idle state, which stays ready. Query outside the map: goes to finish.
// Query inside the map: center, walk over the (2R+1) x (2R+1) square, drain, finish; R = larger
//   radius (saturated); one item at a time, not ready meanwhile.
// The walk reads one neighbor per cycle through the single store read port.
// Reset clears control and sets map 256 x 256, radii 10 and 15; store undefined.
module occupancy_grid_disc_inflation (
   input  logic                        clock,
   input  logic                        reset,
   ogdi_req_if.sink                    req_ch,
   ogdi_rsp_if.source                  rsp_ch,
   input  logic                        csr_wr_en,
   input  ogdi_pkg::csr_index_type     csr_index,
   input  logic [ogdi_pkg::CSR_W-1:0]  csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CENTER = 5'b00010,
      ST_WALK   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   localparam int RSQ_W = 2 * ogdi_pkg::RAD_BITS;
   localparam logic signed [ogdi_pkg::OFF_BITS-1:0] OFF_ONE =
      {{(ogdi_pkg::OFF_BITS - 1){1'b0}}, 1'b1};
   localparam logic signed [ogdi_pkg::SQ_BITS:0] SQ_ONE =
      {{ogdi_pkg::SQ_BITS{1'b0}}, 1'b1};

   state_type state_ff, state_in;

   logic [ogdi_pkg::DIM_W-1:0]     cols_ff, cols_in;
   logic [ogdi_pkg::DIM_W-1:0]     rows_ff, rows_in;
   logic [ogdi_pkg::CFG_RAD_W-1:0] rad_i_ff, rad_i_in;
   logic [ogdi_pkg::CFG_RAD_W-1:0] rad_o_ff, rad_o_in;

   logic [ogdi_pkg::COORD_W-1:0]   col_ff, col_in;
   logic [ogdi_pkg::COORD_W-1:0]   row_ff, row_in;
   logic [ogdi_pkg::RAD_BITS-1:0]  rm_ff, rm_in;
   logic [RSQ_W-1:0]               ri2_ff, ri2_in;
   logic [RSQ_W-1:0]               ro2_ff, ro2_in;
   logic [RSQ_W-1:0]               rm2_ff, rm2_in;
   logic signed [ogdi_pkg::OFF_BITS-1:0] dx_ff, dx_in;
   logic signed [ogdi_pkg::OFF_BITS-1:0] dy_ff, dy_in;
   logic [ogdi_pkg::SQ_BITS-1:0]   sq_dx_ff, sq_dx_in;
   logic [ogdi_pkg::SQ_BITS-1:0]   sq_dy_ff, sq_dy_in;

   logic                           chk_i_ff, chk_i_in;
   logic                           chk_o_ff, chk_o_in;
   logic                           hit_i_ff, hit_i_in;
   logic                           hit_o_ff, hit_o_in;
   logic                           cap_ff, cap_in;
   logic                           outside_ff, outside_in;
   logic signed [ogdi_pkg::VALUE_W-1:0] center_ff, center_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [ogdi_pkg::VALUE_W-1:0] inner_ff, inner_in;
   logic signed [ogdi_pkg::VALUE_W-1:0] outer_ff, outer_in;

   logic [ogdi_pkg::DIM_W-1:0]     width_use;
   logic [ogdi_pkg::DIM_W-1:0]     height_use;
   logic [ogdi_pkg::RAD_BITS-1:0]  ri_use;
   logic [ogdi_pkg::RAD_BITS-1:0]  ro_use;
   logic                           req_inside;
   logic                           req_beat;
   logic                           wr_en;
   logic [ogdi_pkg::ADDR_W-1:0]    wr_addr;
   logic [ogdi_pkg::ADDR_W-1:0]    rd_addr;
   logic [ogdi_pkg::VALUE_W-1:0]   rd_data;
   logic signed [ogdi_pkg::POS_W-1:0] nx;
   logic signed [ogdi_pkg::POS_W-1:0] ny;
   logic                           nb_in_map;
   logic [ogdi_pkg::SQ_BITS:0]     d2;
   logic signed [ogdi_pkg::OFF_BITS-1:0] rm_pos;
   logic signed [ogdi_pkg::SQ_BITS:0] dx_ext;
   logic signed [ogdi_pkg::SQ_BITS:0] dy_ext;
   logic signed [ogdi_pkg::SQ_BITS:0] sq_dx_next;
   logic signed [ogdi_pkg::SQ_BITS:0] sq_dy_next;
   logic                           obstacle;
   logic                           rsp_free;

   ogdi_ram #(
      .WIDTH (ogdi_pkg::VALUE_W),
      .DEPTH (ogdi_pkg::DEPTH)
   ) u_grid_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.cell_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign width_use  = ogdi_pkg::sat_dim(cols_ff, ogdi_pkg::MAX_COLUMNS);
   assign height_use = ogdi_pkg::sat_dim(rows_ff, ogdi_pkg::MAX_ROWS);
   assign ri_use     = ogdi_pkg::sat_radius(rad_i_ff);
   assign ro_use     = ogdi_pkg::sat_radius(rad_o_ff);

   assign req_inside = ({1'b0, req_ch.cell_col} < width_use)
                    && ({1'b0, req_ch.cell_row} < height_use);
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_beat     = req_ch.valid && req_ch.ready;

   assign wr_en   = req_beat && (req_ch.action == ogdi_pkg::ACT_LOAD) && req_inside;
   assign wr_addr = ogdi_pkg::ADDR_W'(req_ch.cell_row) * ogdi_pkg::ADDR_W'(ogdi_pkg::MAX_COLUMNS)
                  + ogdi_pkg::ADDR_W'(req_ch.cell_col);

   // Neighbor under the walk pointer
   assign nx = $signed({2'b00, col_ff}) + ogdi_pkg::POS_W'(dx_ff);
   assign ny = $signed({2'b00, row_ff}) + ogdi_pkg::POS_W'(dy_ff);
   assign nb_in_map = !nx[ogdi_pkg::POS_W-1] && !ny[ogdi_pkg::POS_W-1]
                   && (nx < $signed({1'b0, width_use}))
                   && (ny < $signed({1'b0, height_use}));
   assign d2 = {1'b0, sq_dx_ff} + {1'b0, sq_dy_ff};

   always_comb begin
      if (state_ff == ST_CENTER) begin
         rd_addr = ogdi_pkg::ADDR_W'(row_ff) * ogdi_pkg::ADDR_W'(ogdi_pkg::MAX_COLUMNS)
                 + ogdi_pkg::ADDR_W'(col_ff);
      end else begin
         rd_addr = ogdi_pkg::ADDR_W'(ny[ogdi_pkg::COORD_W-1:0])
                 * ogdi_pkg::ADDR_W'(ogdi_pkg::MAX_COLUMNS)
                 + ogdi_pkg::ADDR_W'(nx[ogdi_pkg::COORD_W-1:0]);
      end
   end

   // Incremental squares: (d+1)^2 = d^2 + 2d + 1
   assign rm_pos     = $signed({1'b0, rm_ff});
   assign dx_ext     = (ogdi_pkg::SQ_BITS + 1)'(dx_ff);
   assign dy_ext     = (ogdi_pkg::SQ_BITS + 1)'(dy_ff);
   assign sq_dx_next = $signed({1'b0, sq_dx_ff}) + dx_ext + dx_ext + SQ_ONE;
   assign sq_dy_next = $signed({1'b0, sq_dy_ff}) + dy_ext + dy_ext + SQ_ONE;

   assign obstacle = $signed(rd_data) > ogdi_pkg::OBSTACLE_LEVEL;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in   = state_ff;
      cols_in    = cols_ff;
      rows_in    = rows_ff;
      rad_i_in   = rad_i_ff;
      rad_o_in   = rad_o_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      rm_in      = rm_ff;
      ri2_in     = ri2_ff;
      ro2_in     = ro2_ff;
      rm2_in     = rm2_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      sq_dx_in   = sq_dx_ff;
      sq_dy_in   = sq_dy_ff;
      chk_i_in   = 1'b0;
      chk_o_in   = 1'b0;
      hit_i_in   = hit_i_ff || (chk_i_ff && obstacle);
      hit_o_in   = hit_o_ff || (chk_o_ff && obstacle);
      cap_in     = 1'b0;
      outside_in = outside_ff;
      center_in  = cap_ff ? $signed(rd_data) : center_ff;
      inner_in   = inner_ff;
      outer_in   = outer_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      if (csr_wr_en) begin
         case (csr_index)
            ogdi_pkg::CSR_MAP_COLUMNS:  cols_in  = csr_wdata;
            ogdi_pkg::CSR_MAP_ROWS:     rows_in  = csr_wdata;
            ogdi_pkg::CSR_INNER_RADIUS: rad_i_in = csr_wdata[ogdi_pkg::CFG_RAD_W-1:0];
            ogdi_pkg::CSR_OUTER_RADIUS: rad_o_in = csr_wdata[ogdi_pkg::CFG_RAD_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat && req_ch.action == ogdi_pkg::ACT_QUERY) begin
               col_in     = req_ch.cell_col;
               row_in     = req_ch.cell_row;
               ri2_in     = RSQ_W'(ri_use) * RSQ_W'(ri_use);
               ro2_in     = RSQ_W'(ro_use) * RSQ_W'(ro_use);
               rm_in      = (ri_use > ro_use) ? ri_use : ro_use;
               outside_in = !req_inside;
               state_in   = req_inside ? ST_CENTER : ST_FINISH;
            end
         end
         ST_CENTER: begin
            // Center read is in flight; set the walk to the top-left corner
            rm2_in   = RSQ_W'(rm_ff) * RSQ_W'(rm_ff);
            dx_in    = -rm_pos;
            dy_in    = -rm_pos;
            sq_dx_in = ogdi_pkg::SQ_BITS'(RSQ_W'(rm_ff) * RSQ_W'(rm_ff));
            sq_dy_in = ogdi_pkg::SQ_BITS'(RSQ_W'(rm_ff) * RSQ_W'(rm_ff));
            hit_i_in = 1'b0;
            hit_o_in = 1'b0;
            cap_in   = 1'b1;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            chk_i_in = nb_in_map && (d2 <= (ogdi_pkg::SQ_BITS + 1)'(ri2_ff));
            chk_o_in = nb_in_map && (d2 <= (ogdi_pkg::SQ_BITS + 1)'(ro2_ff));
            if (dx_ff == rm_pos) begin
               dx_in    = -rm_pos;
               sq_dx_in = ogdi_pkg::SQ_BITS'(rm2_ff);
               dy_in    = dy_ff + OFF_ONE;
               sq_dy_in = sq_dy_next[ogdi_pkg::SQ_BITS-1:0];
               if (dy_ff == rm_pos) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               dx_in    = dx_ff + OFF_ONE;
               sq_dx_in = sq_dx_next[ogdi_pkg::SQ_BITS-1:0];
            end
         end
         ST_DRAIN: begin
            // Last neighbor's data is checked this cycle
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (outside_ff) begin
                  inner_in = ogdi_pkg::UNKNOWN_VALUE;
                  outer_in = ogdi_pkg::UNKNOWN_VALUE;
               end else begin
                  inner_in = hit_i_ff ? ogdi_pkg::LETHAL_VALUE : center_ff;
                  outer_in = hit_o_ff ? ogdi_pkg::LETHAL_VALUE : center_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cols_ff      <= ogdi_pkg::RESET_COLUMNS;
         rows_ff      <= ogdi_pkg::RESET_ROWS;
         rad_i_ff     <= ogdi_pkg::RESET_INNER;
         rad_o_ff     <= ogdi_pkg::RESET_OUTER;
         chk_i_ff     <= 1'b0;
         chk_o_ff     <= 1'b0;
         cap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         rad_i_ff     <= rad_i_in;
         rad_o_ff     <= rad_o_in;
         chk_i_ff     <= chk_i_in;
         chk_o_ff     <= chk_o_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff     <= col_in;
      row_ff     <= row_in;
      rm_ff      <= rm_in;
      ri2_ff     <= ri2_in;
      ro2_ff     <= ro2_in;
      rm2_ff     <= rm2_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      sq_dx_ff   <= sq_dx_in;
      sq_dy_ff   <= sq_dy_in;
      hit_i_ff   <= hit_i_in;
      hit_o_ff   <= hit_o_in;
      outside_ff <= outside_in;
      center_ff  <= center_in;
      inner_ff   <= inner_in;
      outer_ff   <= outer_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.inner_value = inner_ff;
   assign rsp_ch.outer_value = outer_ff;

endmodule

>>> test/occupancy_grid_disc_inflation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid disc inflation testbench
// Programs a series of map sizes and radii, fills each map region before it
// is queried, and sends directed and random load and query beats. A local
// grid model predicts both inflated values of every query, and the monitor
// compares each response beat with the oldest prediction.
// ----------------------------------------------------------------------------
module occupancy_grid_disc_inflation_tb;
   import ogdi_pkg::*;

   localparam int IDLE_LIMIT    = 20000;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      action_type                 act;
      logic [COORD_W-1:0]         col;
      logic [COORD_W-1:0]         row;
      logic signed [VALUE_W-1:0]  value;
   } grid_beat_t;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  inner;
      logic signed [VALUE_W-1:0]  outer;
   } inflated_pair_t;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   csr_index_type       csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   ogdi_req_if req_bus ();
   ogdi_rsp_if rsp_bus ();

   occupancy_grid_disc_inflation u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Grid model and its settings
   logic signed [VALUE_W-1:0] grid_model [DEPTH];
   bit                        cell_loaded [DEPTH];
   int                        map_cols_reg;
   int                        map_rows_reg;
   int                        inner_radius_reg;
   int                        outer_radius_reg;

   grid_beat_t     beat_backlog [$];
   inflated_pair_t pending_pairs [$];

   int  beats_issued;
   int  beats_accepted;
   int  mismatches;
   int  idle_cycles;
   int  send_gap;
   int  send_quiet;
   int  take_gap;
   int  take_quiet;
   int  hold_left;
   int  stall_asked;
   int  stall_seen;
   grid_beat_t next_beat;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int cols_in_use();
      return (map_cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : map_cols_reg;
   endfunction

   function automatic int rows_in_use();
      return (map_rows_reg > MAX_ROWS) ? MAX_ROWS : map_rows_reg;
   endfunction

   // Any cell above the obstacle level within the disc makes the cell lethal.
   function automatic logic signed [VALUE_W-1:0] disc_inflate(int col, int row, int radius);
      int r;
      int w;
      int h;
      int nx;
      int ny;
      r = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
      w = cols_in_use();
      h = rows_in_use();
      for (int dy = -r; dy <= r; dy++) begin
         for (int dx = -r; dx <= r; dx++) begin
            nx = col + dx;
            ny = row + dy;
            if (dx * dx + dy * dy <= r * r && nx >= 0 && nx < w && ny >= 0 && ny < h) begin
               if (grid_model[ny * MAX_COLUMNS + nx] > OBSTACLE_LEVEL) begin
                  return LETHAL_VALUE;
               end
            end
         end
      end
      return grid_model[row * MAX_COLUMNS + col];
   endfunction

   function automatic void apply_beat(grid_beat_t b);
      int col;
      int row;
      bit in_map;
      inflated_pair_t pair;
      col = int'(b.col);
      row = int'(b.row);
      in_map = (col < cols_in_use()) && (row < rows_in_use());
      if (b.act == ACT_LOAD) begin
         if (in_map) begin
            grid_model[row * MAX_COLUMNS + col] = b.value;
            cell_loaded[row * MAX_COLUMNS + col] = 1'b1;
         end
      end else begin
         if (in_map) begin
            pair.inner = disc_inflate(col, row, inner_radius_reg);
            pair.outer = disc_inflate(col, row, outer_radius_reg);
         end else begin
            pair.inner = UNKNOWN_VALUE;
            pair.outer = UNKNOWN_VALUE;
         end
         pending_pairs.push_back(pair);
      end
   endfunction

   function automatic void note_mismatch(string what, logic signed [VALUE_W-1:0] want,
                                         logic signed [VALUE_W-1:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("[%0t] %s mismatch: expected %0d, actual %0d", $realtime, what, want, got);
      end
   endfunction

   function automatic void check_pair(inflated_pair_t got);
      inflated_pair_t want;
      if (pending_pairs.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] unexpected response beat: inner %0d, outer %0d",
                     $realtime, got.inner, got.outer);
         end
      end else begin
         want = pending_pairs.pop_front();
         if (got.inner !== want.inner) note_mismatch("inner_value", want.inner, got.inner);
         if (got.outer !== want.outer) note_mismatch("outer_value", want.outer, got.outer);
      end
   endfunction

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_radius();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 6);
      if (r < 90) return $urandom_range(7, 15);
      return $urandom_range(16, 31);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_cell_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return VALUE_W'($urandom_range(0, 50));
      if (r < 75) return VALUE_W'($urandom_range(51, 100));
      if (r < 85) return UNKNOWN_VALUE;
      return VALUE_W'($urandom);
   endfunction

   function automatic grid_beat_t make_beat(action_type a, int col, int row, int value);
      grid_beat_t b;
      b.act   = a;
      b.col   = COORD_W'(col);
      b.row   = COORD_W'(row);
      b.value = VALUE_W'(value);
      return b;
   endfunction

   function automatic void push_beat(grid_beat_t b);
      beat_backlog.push_back(b);
      beats_issued++;
   endfunction

   // Mostly well-formed traffic inside the map, the rest outside or raw.
   function automatic grid_beat_t random_beat();
      int w;
      int h;
      int r;
      grid_beat_t b;
      w = cols_in_use();
      h = rows_in_use();
      r = $urandom_range(0, 99);
      b.value = VALUE_W'($urandom);
      b.act   = action_type'($urandom_range(0, 1));
      b.col   = COORD_W'($urandom);
      b.row   = COORD_W'($urandom);
      if (r < 75 && w > 0 && h > 0) begin
         b.act   = (r < 40) ? ACT_QUERY : ACT_LOAD;
         b.col   = COORD_W'($urandom_range(0, w - 1));
         b.row   = COORD_W'($urandom_range(0, h - 1));
         b.value = pick_cell_value();
      end else if (r < 90) begin
         if (w < MAX_COLUMNS && (h >= MAX_ROWS || $urandom_range(0, 1) == 1)) begin
            b.col = COORD_W'($urandom_range(w, MAX_COLUMNS - 1));
         end else if (h < MAX_ROWS) begin
            b.row = COORD_W'($urandom_range(h, MAX_ROWS - 1));
         end
      end
      return b;
   endfunction

   task automatic program_map(input int cols, input int rows, input int inner, input int outer);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAP_COLUMNS;
      csr_wdata <= CSR_W'(cols);
      @(posedge clock);
      csr_index <= CSR_MAP_ROWS;
      csr_wdata <= CSR_W'(rows);
      @(posedge clock);
      csr_index <= CSR_INNER_RADIUS;
      csr_wdata <= CSR_W'(inner);
      @(posedge clock);
      csr_index <= CSR_OUTER_RADIUS;
      csr_wdata <= CSR_W'(outer);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      map_cols_reg     = cols & 9'h1FF;
      map_rows_reg     = rows & 9'h1FF;
      inner_radius_reg = inner & 5'h1F;
      outer_radius_reg = outer & 5'h1F;
   endtask

   // Load every never-written cell of a window of the map.
   task automatic fill_window(input int col_lo, input int col_hi,
                              input int row_lo, input int row_hi);
      int r;
      logic signed [VALUE_W-1:0] v;
      for (int row = row_lo; row <= row_hi; row++) begin
         for (int col = col_lo; col <= col_hi; col++) begin
            if (!cell_loaded[row * MAX_COLUMNS + col]) begin
               r = $urandom_range(0, 99);
               if (r < 90) v = VALUE_W'($urandom_range(0, 50));
               else if (r < 95) v = UNKNOWN_VALUE;
               else v = VALUE_W'($urandom_range(51, 100));
               push_beat(make_beat(ACT_LOAD, col, row, int'(v)));
               cell_loaded[row * MAX_COLUMNS + col] = 1'b1;
            end
         end
      end
   endtask

   // Load every cell of the region in use that was never written.
   task automatic fill_region();
      fill_window(0, cols_in_use() - 1, 0, rows_in_use() - 1);
   endtask

   // Loads give no response, so settle for SETTLE_CYCLES after the last beat.
   task automatic wait_quiet();
      while (beats_accepted != beats_issued || pending_pairs.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int cols, input int rows, input int inner, input int outer,
                            input int count, input bit squeeze);
      program_map(cols, rows, inner, outer);
      fill_region();
      for (int k = 0; k < count; k++) begin
         push_beat(random_beat());
      end
      if (squeeze) stall_asked++;
      wait_quiet();
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap   = 0;
         send_quiet = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            if (send_quiet > 0) begin
               send_quiet--;
               send_gap = 0;
            end else begin
               send_gap = pick_gap();
               if ($urandom_range(0, 19) == 0) send_quiet = $urandom_range(20, 60);
            end
         end
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (beat_backlog.size() != 0) begin
            next_beat = beat_backlog.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.action     <= next_beat.act;
            req_bus.cell_col   <= next_beat.col;
            req_bus.cell_row   <= next_beat.row;
            req_bus.cell_value <= next_beat.value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response ready: random gaps, quiet stretches, and the long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left  = 0;
         take_gap   = 0;
         take_quiet = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_seen != stall_asked) begin
         stall_seen = stall_asked;
         hold_left  = LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (take_gap > 0) begin
         take_gap--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (take_quiet > 0) begin
            take_quiet--;
         end else if ($urandom_range(0, 3) == 0) begin
            take_gap = pick_gap();
            if ($urandom_range(0, 19) == 0) take_quiet = $urandom_range(50, 200);
         end
      end
   end

   // Monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_beat(make_beat(action_type'(req_bus.action), int'(req_bus.cell_col),
                                 int'(req_bus.cell_row), int'(req_bus.cell_value)));
            beats_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_pair('{inner: rsp_bus.inner_value, outer: rsp_bus.outer_value});
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_LOAD;
      req_bus.cell_col   = '0;
      req_bus.cell_row   = '0;
      req_bus.cell_value = '0;
      rsp_bus.ready      = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_MAP_COLUMNS;
      csr_wdata          = '0;
      beats_issued       = 0;
      beats_accepted     = 0;
      mismatches         = 0;
      stall_asked        = 0;
      stall_seen         = 0;
      map_cols_reg       = int'(RESET_COLUMNS);
      map_rows_reg       = int'(RESET_ROWS);
      inner_radius_reg   = int'(RESET_INNER);
      outer_radius_reg   = int'(RESET_OUTER);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: small 4 x 3 map, inner disc is the cell alone
      program_map(4, 3, 0, 2);
      fill_region();
      push_beat(make_beat(ACT_LOAD, 0, 0, 127));
      push_beat(make_beat(ACT_LOAD, 3, 2, -128));
      push_beat(make_beat(ACT_LOAD, 1, 1, -1));
      push_beat(make_beat(ACT_LOAD, 2, 1, 50));
      push_beat(make_beat(ACT_LOAD, 2, 0, 10));
      push_beat(make_beat(ACT_QUERY, 3, 2, 0));
      push_beat(make_beat(ACT_QUERY, 0, 0, 0));
      push_beat(make_beat(ACT_QUERY, 1, 1, 0));
      push_beat(make_beat(ACT_QUERY, 2, 1, 0));
      // obstacle just above the level next to a cell sitting at the level
      push_beat(make_beat(ACT_LOAD, 2, 0, 51));
      push_beat(make_beat(ACT_QUERY, 2, 1, 0));
      // load and queries outside the map, then a query at its top-right corner
      push_beat(make_beat(ACT_LOAD, 200, 1, 100));
      push_beat(make_beat(ACT_QUERY, 200, 1, 0));
      push_beat(make_beat(ACT_QUERY, 1, 255, 0));
      push_beat(make_beat(ACT_QUERY, 255, 255, 0));
      push_beat(make_beat(ACT_QUERY, 3, 0, 0));
      wait_quiet();

      // zero-sized maps: every coordinate lies outside
      run_phase(0, 7, 3, 4, 8, 1'b0);
      run_phase(5, 0, 2, 1, 6, 1'b0);

      // oversized dimensions saturate: query the far end of a single row,
      // where a wrapped walk would reach the obstacle at the origin
      program_map(511, 1, 6, 2);
      fill_window(MAX_COLUMNS - 12, MAX_COLUMNS - 1, 0, 0);
      for (int col = MAX_COLUMNS - 6; col < MAX_COLUMNS; col++) begin
         push_beat(make_beat(ACT_QUERY, col, 0, 0));
      end
      wait_quiet();
      // same along a single column
      program_map(1, 300, 2, 8);
      fill_window(0, 0, MAX_ROWS - 16, MAX_ROWS - 1);
      for (int row = MAX_ROWS - 6; row < MAX_ROWS; row++) begin
         push_beat(make_beat(ACT_QUERY, 0, row, 0));
      end
      wait_quiet();

      // hold off responses while queries keep coming
      run_phase(4, 3, 1, 2, 16, 1'b1);
      for (int k = 0; k < 4; k++) begin
         run_phase($urandom_range(1, 4), $urandom_range(1, 4), pick_radius(), pick_radius(),
                   8, 1'b0);
      end
      wait_quiet();

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/ogdi_pkg.sv
hw/rtl/ogdi_if.sv
hw/rtl/ogdi_ram.sv
hw/rtl/occupancy_grid_disc_inflation.sv
test/occupancy_grid_disc_inflation_tb.sv
